>>> design/rbcs_pkg.sv
// ----------------------------------------------------------------------------
// rbcs_pkg: shared types and constants of the bytecode step core
// Field widths, opcode codes, cycle costs, instruction lengths and the
// structs passed between the register file, execute unit and top level.
// ----------------------------------------------------------------------------
package rbcs_pkg;

  localparam int DATA_W      = 32;
  localparam int PC_W        = 16;
  localparam int NEXT_PC_W   = 16;
  localparam int RF_DEPTH    = 16;
  localparam int RF_AW       = $clog2(RF_DEPTH);
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  localparam logic [7:0] OP_RET  = 8'd0;
  localparam logic [7:0] OP_ADD  = 8'd1;
  localparam logic [7:0] OP_SUB  = 8'd2;
  localparam logic [7:0] OP_MOV  = 8'd3;
  localparam logic [7:0] OP_MOVI = 8'd4;
  localparam logic [7:0] OP_BR   = 8'd5;
  localparam logic [7:0] OP_BRNZ = 8'd6;

  localparam logic MODE_START = 1'b0;

  localparam logic [DATA_W-1:0] COST_RET   = 32'd1;
  localparam logic [DATA_W-1:0] COST_MOVI  = 32'd6;
  localparam logic [DATA_W-1:0] COST_OTHER = 32'd2;

  localparam logic [PC_W-1:0] LEN_RET   = PC_W'(1);
  localparam logic [PC_W-1:0] LEN_MOVI  = PC_W'(6);
  localparam logic [PC_W-1:0] LEN_OTHER = PC_W'(2);

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] start_value;
    logic [7:0]               opcode;
    logic [7:0]               operand_byte;
    logic signed [DATA_W-1:0] immediate;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]    cycle_total;
    logic [DATA_W-1:0]    result_value;
    logic                 bad_opcode;
    logic                 halted;
    logic [NEXT_PC_W-1:0] next_pc;
  } result_t;

  // register file write port; clear drops every entry back to zero first
  typedef struct packed {
    logic              en;
    logic              clear;
    logic [RF_AW-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wb_t;

endpackage

>>> design/rbcs_ram.sv
// ----------------------------------------------------------------------------
// rbcs_ram: generic RAM, one write port, two registered read ports
// Reads return the contents before a write at the same edge.
// ----------------------------------------------------------------------------
module rbcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> design/rbcs_regfile.sv
// ----------------------------------------------------------------------------
// rbcs_regfile: 16 x 32 register file with valid bits and write bypass
// Operands are read when an item enters the input register; an entry not
// written since the last clear reads as zero, and a write at the same edge
// is forwarded.
// ----------------------------------------------------------------------------
module rbcs_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [rbcs_pkg::RF_AW-1:0]    rd_addr_a,
  input  logic [rbcs_pkg::RF_AW-1:0]    rd_addr_b,
  input  rbcs_pkg::wb_t                 wb,
  output logic [rbcs_pkg::DATA_W-1:0]   rd_data_a,
  output logic [rbcs_pkg::DATA_W-1:0]   rd_data_b
);
  import rbcs_pkg::*;

  logic [RF_DEPTH-1:0] valid_r, valid_nxt;
  logic                a_hit_r, a_vld_r, b_hit_r, b_vld_r;
  logic [DATA_W-1:0]   a_byp_r, b_byp_r;
  logic [DATA_W-1:0]   ram_a, ram_b;

  rbcs_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_ram (
    .clk     (clk),
    .we      (wb.en),
    .waddr   (wb.addr),
    .wdata   (wb.data),
    .re      (rd_en),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_comb begin
    valid_nxt = wb.clear ? '0 : valid_r;
    if (wb.en) begin
      valid_nxt[wb.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      a_hit_r <= 1'b0;
      a_vld_r <= 1'b0;
      b_hit_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd_en) begin
        a_hit_r <= wb.en && (wb.addr == rd_addr_a);
        a_vld_r <= valid_nxt[rd_addr_a];
        b_hit_r <= wb.en && (wb.addr == rd_addr_b);
        b_vld_r <= valid_nxt[rd_addr_b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_byp_r <= wb.data;
      b_byp_r <= wb.data;
    end
  end

  assign rd_data_a = a_hit_r ? a_byp_r : (a_vld_r ? ram_a : '0);
  assign rd_data_b = b_hit_r ? b_byp_r : (b_vld_r ? ram_b : '0);

  // a clear leaves only the entry written with it
  assert property (@(posedge clk) disable iff (!rst_n)
    wb.en && wb.clear |=> $countones(valid_r) == 1)
    else $error("regfile clear left stale entries");

  // a write always marks its entry
  assert property (@(posedge clk) disable iff (!rst_n)
    wb.en |=> valid_r[$past(wb.addr)])
    else $error("regfile write did not set valid");

endmodule

>>> design/rbcs_exec.sv
// ----------------------------------------------------------------------------
// rbcs_exec: execute unit and architectural state
// Holds pc, flags, cycle count, halt mark and a copy of register 0; decodes
// one item per fire and produces the write-back and the result.
// ----------------------------------------------------------------------------
module rbcs_exec (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  rbcs_pkg::item_t               item,
  input  logic [rbcs_pkg::DATA_W-1:0]   dest_val,
  input  logic [rbcs_pkg::DATA_W-1:0]   src_val,
  output rbcs_pkg::wb_t                 wb,
  output rbcs_pkg::result_t             res
);
  import rbcs_pkg::*;

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [DATA_W-1:0] cyc_r, cyc_nxt;
  logic [DATA_W-1:0] r0_r, r0_nxt;
  logic              zf_r, zf_nxt, nf_r, nf_nxt, halt_r, halt_nxt;
  logic              bad;
  logic [DATA_W-1:0] alu;
  logic [PC_W-1:0]   br_target;
  wb_t               wb_c;

  assign br_target = pc_r + LEN_OTHER + PC_W'($signed(item.operand_byte));

  always_comb begin
    pc_nxt    = pc_r;
    cyc_nxt   = cyc_r;
    zf_nxt    = zf_r;
    nf_nxt    = nf_r;
    halt_nxt  = halt_r;
    bad       = 1'b0;
    alu       = '0;
    wb_c.en    = 1'b0;
    wb_c.clear = 1'b0;
    wb_c.addr  = item.operand_byte[7:4];
    wb_c.data  = '0;
    if (item.mode == MODE_START) begin
      pc_nxt     = '0;
      cyc_nxt    = '0;
      zf_nxt     = 1'b0;
      nf_nxt     = 1'b0;
      halt_nxt   = 1'b0;
      wb_c.en    = 1'b1;
      wb_c.clear = 1'b1;
      wb_c.addr  = '0;
      wb_c.data  = item.start_value;
    end else if (!halt_r) begin
      case (item.opcode)
        OP_RET: begin
          cyc_nxt  = cyc_r + COST_RET;
          halt_nxt = 1'b1;
          pc_nxt   = pc_r + LEN_RET;
        end
        OP_ADD, OP_SUB: begin
          alu       = (item.opcode == OP_ADD) ? dest_val + src_val : dest_val - src_val;
          wb_c.en   = 1'b1;
          wb_c.data = alu;
          zf_nxt    = (alu == '0);
          nf_nxt    = alu[DATA_W-1];
          cyc_nxt   = cyc_r + COST_OTHER;
          pc_nxt    = pc_r + LEN_OTHER;
        end
        OP_MOV: begin
          wb_c.en   = 1'b1;
          wb_c.data = src_val;
          cyc_nxt   = cyc_r + COST_OTHER;
          pc_nxt    = pc_r + LEN_OTHER;
        end
        OP_MOVI: begin
          wb_c.en   = 1'b1;
          wb_c.data = item.immediate;
          cyc_nxt   = cyc_r + COST_MOVI;
          pc_nxt    = pc_r + LEN_MOVI;
        end
        OP_BR: begin
          pc_nxt  = br_target;
          cyc_nxt = cyc_r + COST_OTHER;
        end
        OP_BRNZ: begin
          pc_nxt  = zf_r ? pc_r + LEN_OTHER : br_target;
          cyc_nxt = cyc_r + COST_OTHER;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end
    r0_nxt = (wb_c.en && wb_c.addr == '0) ? wb_c.data : r0_r;
  end

  // write and clear only take effect on the executing edge
  always_comb begin
    wb       = wb_c;
    wb.en    = wb_c.en && fire;
    wb.clear = wb_c.clear && fire;
    res.next_pc      = NEXT_PC_W'(pc_nxt);
    res.halted       = halt_nxt;
    res.bad_opcode   = bad;
    res.result_value = r0_nxt;
    res.cycle_total  = cyc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      cyc_r  <= '0;
      r0_r   <= '0;
      zf_r   <= 1'b0;
      nf_r   <= 1'b0;
      halt_r <= 1'b0;
    end else if (fire) begin
      pc_r   <= pc_nxt;
      cyc_r  <= cyc_nxt;
      r0_r   <= r0_nxt;
      zf_r   <= zf_nxt;
      nf_r   <= nf_nxt;
      halt_r <= halt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == MODE_START |=> pc_r == '0 && cyc_r == '0 && !halt_r)
    else $error("start did not clear machine state");

  assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode != MODE_START && halt_r |=> $stable(pc_r) && $stable(cyc_r))
    else $error("halted machine changed state");

  assert property (@(posedge clk) disable iff (!rst_n)
    fire && bad |=> $stable(cyc_r) && $stable(r0_r) && $stable(pc_r))
    else $error("undefined opcode changed state");

endmodule

>>> design/register_bytecode_cpu_step.sv
// ----------------------------------------------------------------------------
// register_bytecode_cpu_step: one-instruction step of a 16-register machine
// Input register, execute unit with register file, result register.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / tuser
//  in_     | in  | tuser: mode; tdata: start_value, opcode, operand_byte, immediate
//  out_    | out | tdata: next_pc, halted, bad_opcode, result_value, cycle_total
//
//  one item per cycle sustained while out_tready stays high; an item passes
//  through the input register and then the result register; operands are read
//  from the register file ram as the item enters the input register; a write
//  from the item ahead is forwarded; reset clears the valid flags and machine
//  state at once, with no clearing pass; a stalled output holds the input register, which then drops in_tready
// ----------------------------------------------------------------------------
module register_bytecode_cpu_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_value[31:0], opcode[39:32], operand_byte[47:40], immediate[79:48]
  input  logic [rbcs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // next_pc[15:0], halted[16], bad_opcode[17], result_value[49:18],
  // cycle_total[81:50], zero[87:82]
  output logic [rbcs_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import rbcs_pkg::*;

  logic              s1_valid_r;
  item_t             s1_item_r;
  item_t             in_item;
  logic              in_fire, ex_fire;
  logic [DATA_W-1:0] dest_val, src_val;
  wb_t               wb;
  result_t           res;
  logic              out_valid_r;
  result_t           out_res_r;

  assign in_item.mode         = in_tuser;
  assign in_item.start_value  = in_tdata[31:0];
  assign in_item.opcode       = in_tdata[39:32];
  assign in_item.operand_byte = in_tdata[47:40];
  assign in_item.immediate    = in_tdata[79:48];

  assign ex_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || ex_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (ex_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (ex_fire) begin
      out_res_r <= res;
    end
  end

  rbcs_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_item.operand_byte[7:4]),
    .rd_addr_b (in_item.operand_byte[3:0]),
    .wb        (wb),
    .rd_data_a (dest_val),
    .rd_data_b (src_val)
  );

  rbcs_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (ex_fire),
    .item     (s1_item_r),
    .dest_val (dest_val),
    .src_val  (src_val),
    .wb       (wb),
    .res      (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res_r};

  // a blocked input means an item is waiting in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r)
    else $error("input blocked with no pending item");

endmodule
